// File: rtl/xoshiro_pkg.sv
// Shared types, constants and micro-step addresses of the xoshiro256++ generator.
// Depends on nothing; the sequencer and the top level import it.
package xoshiro_pkg;

  localparam int WORD_W   = 64;
  localparam int NWORDS   = 4;
  localparam int POLY_W   = NWORDS * WORD_W;       // 256-bit state / jump polynomial
  localparam int BMP_W    = POLY_W + 1;            // connection polynomial, degree <= 256
  localparam int SQ_IDX_W = $clog2(POLY_W);
  localparam int CNT_W    = $clog2(2 * POLY_W);    // counts 512 sequence bits
  localparam int LEN_W    = $clog2(POLY_W) + 1;    // linear complexity 0..256
  localparam int BITC_W   = $clog2(WORD_W);
  localparam int UPC_W    = 5;
  localparam int OPC_W    = 3;
  localparam int HALF_W   = WORD_W / 2;

  typedef logic [NWORDS-1:0][WORD_W-1:0] words_t;
  typedef logic [POLY_W-1:0]             poly_t;
  typedef logic [BMP_W-1:0]              bmp_t;
  typedef logic [UPC_W-1:0]              upc_t;

  typedef enum logic [OPC_W-1:0] {
    OPC_NEXT      = 3'd0,
    OPC_SEED      = 3'd1,
    OPC_DISCARD   = 3'd2,
    OPC_JUMP      = 3'd3,
    OPC_LONG_JUMP = 3'd4
  } opcode_t;

  // datapath operation of one micro-step
  typedef enum logic [4:0] {
    OP_IDLE, OP_BOOT, OP_EXP_MIX, OP_MUL_LL, OP_MUL_HL, OP_MUL_LH, OP_MIX27,
    OP_WORD_SHIFT, OP_NOP, OP_BM_INIT, OP_BM_STEP, OP_BM_FIN, OP_POW_INIT,
    OP_SQ_START, OP_SQ_STEP, OP_POW_BIT, OP_ACC_CLEAR, OP_APPLY_STEP, OP_WORD_LOAD
  } dp_op_t;

  typedef enum logic [1:0] {LD_NONE, LD_3, LD_255, LD_511} cnt_ld_t;

  typedef enum logic [2:0] {
    JMP_NEXT, JMP_ALWAYS, JMP_LOOP, JMP_LOOP_BIT, JMP_IF_NZERO, JMP_IF_CHARP,
    JMP_DISPATCH
  } jmp_t;

  typedef struct packed {
    dp_op_t  op;
    cnt_ld_t ld;
    logic    bit_ld;
    logic    mul_b;
    jmp_t    jmp;
    upc_t    target;
  } ctl_t;

  typedef struct packed {
    logic             in_fire;
    logic [OPC_W-1:0] opcode;
    logic             n_zero;
    logic             charp_ok;
  } seq_stat_t;

  // micro-program addresses
  localparam upc_t UPC_IDLE     = 5'd0;
  localparam upc_t UPC_BOOT     = 5'd1;
  localparam upc_t UPC_SEED_MIX = 5'd2;
  localparam upc_t UPC_SEED_LLA = 5'd3;
  localparam upc_t UPC_SEED_HLA = 5'd4;
  localparam upc_t UPC_SEED_LHA = 5'd5;
  localparam upc_t UPC_SEED_M27 = 5'd6;
  localparam upc_t UPC_SEED_LLB = 5'd7;
  localparam upc_t UPC_SEED_HLB = 5'd8;
  localparam upc_t UPC_SEED_LHB = 5'd9;
  localparam upc_t UPC_SEED_WR  = 5'd10;
  localparam upc_t UPC_SEED_END = 5'd11;
  localparam upc_t UPC_DIS_ZERO = 5'd12;
  localparam upc_t UPC_DIS_CHK  = 5'd13;
  localparam upc_t UPC_BM_INIT  = 5'd14;
  localparam upc_t UPC_BM_STEP  = 5'd15;
  localparam upc_t UPC_BM_FIN   = 5'd16;
  localparam upc_t UPC_POW_INIT = 5'd17;
  localparam upc_t UPC_SQ_START = 5'd18;
  localparam upc_t UPC_SQ_STEP  = 5'd19;
  localparam upc_t UPC_POW_BIT  = 5'd20;
  localparam upc_t UPC_ACC_CLR  = 5'd21;
  localparam upc_t UPC_APPLY    = 5'd22;
  localparam upc_t UPC_LOAD     = 5'd23;

  localparam logic [WORD_W-1:0] MIX_GAMMA = 64'h9e3779b97f4a7c15;
  localparam logic [WORD_W-1:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
  localparam logic [WORD_W-1:0] MIX_MUL_B = 64'h94d049bb133111eb;

  localparam poly_t SHORT_POLY = {64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
                                  64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba};
  localparam poly_t LONG_POLY  = {64'h39109bb02acbe635, 64'h77710069854ee241,
                                  64'hc5004e441c522fb3, 64'h76e15d3efefdcbbf};

  localparam int ROT_OUT = 23;
  localparam int SHL_UPD = 17;
  localparam int ROT_UPD = 45;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int k);
    rotl = (x << k) | (x >> (WORD_W - k));
  endfunction

  // ++ scrambler on the current words
  function automatic logic [WORD_W-1:0] pp_out(input words_t w);
    pp_out = rotl(w[0] + w[3], ROT_OUT) + w[0];
  endfunction

  // one linear state update
  function automatic words_t advance(input words_t w);
    words_t r;
    logic [WORD_W-1:0] sh;
    r  = w;
    sh = w[1] << SHL_UPD;
    r[2] = r[2] ^ r[0];
    r[3] = r[3] ^ r[1];
    r[1] = r[1] ^ r[2];
    r[0] = r[0] ^ r[3];
    r[2] = r[2] ^ sh;
    r[3] = rotl(r[3], ROT_UPD);
    advance = r;
  endfunction

endpackage

// File: rtl/xoshiro256pp_generator.sv
// Top level of the xoshiro256++ generator: datapath driven by xoshiro_seq.
// Depends on xoshiro_pkg and xoshiro_seq.
//
// Usage. One input channel (in_valid/in_ready) carries a word with in_opcode,
// in_seed_value and in_skip_count; one result channel (out_valid/out_ready)
// carries out_random_value. Only "next" returns a word.
// Next: taken and done in the idle step; result registered,
//   so a stream of next words runs at one per cycle while out_ready stays high.
// Seed: four splitmix64 outputs, each through a shared 32x32 multiplier,
//   three passes per 64-bit product.
// Jump / long jump: one state update per polynomial bit.
// Discard: x^n mod P(x) by square and multiply, then a jump by the
//   256-bit result polynomial; a zero count does nothing.
//   P(x), the characteristic polynomial of the update, is found once by
//   Berlekamp-Massey over 512 generated bits on the first discard after reset
//   and kept.
// Reset: the state is seeded from zero by the seed micro-program; in_ready
//   stays low after reset is released until the seeding is done.
// Stall: in_ready needs the idle step and a free output register; a stalled
//   receiver holds the result and blocks only the next item.
module xoshiro256pp_generator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [xoshiro_pkg::OPC_W-1:0]   in_opcode,
  input  logic [xoshiro_pkg::WORD_W-1:0]  in_seed_value,
  input  logic [xoshiro_pkg::WORD_W-1:0]  in_skip_count,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [xoshiro_pkg::WORD_W-1:0]  out_random_value
);
  import xoshiro_pkg::*;

  ctl_t             ctl;
  seq_stat_t        stat;
  logic [CNT_W-1:0] cnt;

  // generator words and jump accumulator (also the scratch state for BM)
  words_t w_r, w_nxt;
  words_t acc_r, acc_nxt;
  // splitmix64 expander
  logic [WORD_W-1:0] exp_r, exp_nxt;
  logic [WORD_W-1:0] mix_r, mix_nxt;
  logic [WORD_W-1:0] prod_r, prod_nxt;
  // discard count, shifted out MSB first
  logic [WORD_W-1:0] n_r, n_nxt;
  // jump polynomial / power accumulator, squaring operand, char poly
  poly_t q_r, q_nxt;
  poly_t sq_r, sq_nxt;
  poly_t charp_r, charp_nxt;
  logic  charp_ok_r, charp_ok_nxt;
  // Berlekamp-Massey registers
  bmp_t             c_r, c_nxt;
  bmp_t             bs_r, bs_nxt;      // x^m * B, kept pre-shifted
  bmp_t             hist_r, hist_nxt;  // hist[i] = s[N-i]
  logic [LEN_W-1:0] l_r, l_nxt;
  // result register
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_val_r, out_val_nxt;

  logic              in_fire;
  logic [WORD_W-1:0] kmul;
  logic [HALF_W-1:0] mul_x, mul_y;
  logic [WORD_W-1:0] mul_p;
  logic [WORD_W-1:0] z_sum;
  logic [WORD_W-1:0] new_word;
  bmp_t              hist_n;
  logic              bm_d;
  logic [CNT_W-1:0]  bm_n;
  poly_t             charp_rev;
  poly_t             q_mulx;

  function automatic poly_t mulx(input poly_t v, input poly_t p);
    mulx = {v[POLY_W-2:0], 1'b0} ^ (v[POLY_W-1] ? p : '0);
  endfunction

  xoshiro_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl),
    .cnt   (cnt)
  );

  assign in_ready  = (ctl.op == OP_IDLE) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;

  assign stat.in_fire  = in_fire;
  assign stat.opcode   = in_opcode;
  assign stat.n_zero   = (n_r == '0);
  assign stat.charp_ok = charp_ok_r;

  assign out_valid        = out_valid_r;
  assign out_random_value = out_val_r;

  // one shared 32x32 multiplier for the 64-bit products
  assign kmul = ctl.mul_b ? MIX_MUL_B : MIX_MUL_A;
  always_comb begin
    mul_x = mix_r[HALF_W-1:0];
    mul_y = kmul[HALF_W-1:0];
    case (ctl.op)
      OP_MUL_HL: mul_x = mix_r[WORD_W-1:HALF_W];
      OP_MUL_LH: mul_y = kmul[WORD_W-1:HALF_W];
      default: ;
    endcase
  end
  assign mul_p = {{HALF_W{1'b0}}, mul_x} * {{HALF_W{1'b0}}, mul_y};

  assign z_sum    = exp_r + MIX_GAMMA;
  assign new_word = prod_r ^ (prod_r >> 31);
  assign q_mulx   = mulx(q_r, charp_r);

  // BM discrepancy on the newest sequence bit (bit 0 of scratch word 0)
  assign hist_n = {hist_r[BMP_W-2:0], acc_r[0][0]};
  assign bm_d   = ^(c_r & hist_n);
  assign bm_n   = ~cnt;            // counter runs 511..0, so N = 0..511

  // P(x) = x^256 C(1/x); the monic top term is implied
  always_comb begin
    for (int k = 0; k < POLY_W; k++) charp_rev[k] = c_r[POLY_W-k];
  end

  always_comb begin
    w_nxt         = w_r;
    acc_nxt       = acc_r;
    exp_nxt       = exp_r;
    mix_nxt       = mix_r;
    prod_nxt      = prod_r;
    n_nxt         = n_r;
    q_nxt         = q_r;
    sq_nxt        = sq_r;
    charp_nxt     = charp_r;
    charp_ok_nxt  = charp_ok_r;
    c_nxt         = c_r;
    bs_nxt        = bs_r;
    hist_nxt      = hist_r;
    l_nxt         = l_r;
    out_val_nxt   = out_val_r;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (ctl.op)
      OP_IDLE: begin
        if (in_fire) begin
          case (in_opcode)
            OPC_NEXT: begin
              w_nxt         = advance(w_r);
              out_val_nxt   = pp_out(w_r);
              out_valid_nxt = 1'b1;
            end
            OPC_SEED:      exp_nxt = in_seed_value;
            OPC_DISCARD:   n_nxt   = in_skip_count;
            OPC_JUMP:      q_nxt   = SHORT_POLY;
            OPC_LONG_JUMP: q_nxt   = LONG_POLY;
            default: ;     // unused codes are dropped
          endcase
        end
      end
      OP_BOOT:    exp_nxt = '0;
      OP_EXP_MIX: begin
        exp_nxt = z_sum;
        mix_nxt = z_sum ^ (z_sum >> 30);
      end
      OP_MUL_LL:  prod_nxt = mul_p;
      OP_MUL_HL, OP_MUL_LH: prod_nxt = prod_r + {mul_p[HALF_W-1:0], {HALF_W{1'b0}}};
      OP_MIX27:   mix_nxt = prod_r ^ (prod_r >> 27);
      OP_WORD_SHIFT: begin
        // four passes leave the first output in word 0
        for (int k = 0; k < NWORDS - 1; k++) w_nxt[k] = w_r[k+1];
        w_nxt[NWORDS-1] = new_word;
      end
      OP_NOP: ;
      OP_BM_INIT: begin
        acc_nxt    = '0;
        acc_nxt[0] = WORD_W'(1);
        c_nxt      = BMP_W'(1);
        bs_nxt     = BMP_W'(2);
        l_nxt      = '0;
        hist_nxt   = '0;
      end
      OP_BM_STEP: begin
        hist_nxt = hist_n;
        acc_nxt  = advance(acc_r);
        bs_nxt   = {bs_r[BMP_W-2:0], 1'b0};
        if (bm_d) begin
          c_nxt = c_r ^ bs_r;
          if ({l_r, 1'b0} <= {1'b0, bm_n}) begin
            l_nxt  = LEN_W'(({1'b0, bm_n} + 1'b1) - {1'b0, l_r});
            bs_nxt = {c_r[BMP_W-2:0], 1'b0};
          end
        end
      end
      OP_BM_FIN: begin
        charp_nxt    = charp_rev;
        charp_ok_nxt = 1'b1;
      end
      OP_POW_INIT: q_nxt = POLY_W'(1);
      OP_SQ_START: begin
        sq_nxt = q_r;
        q_nxt  = '0;
      end
      OP_SQ_STEP: begin
        // Horner: q = q*x + sq[i]*sq, i from 255 down to 0
        q_nxt = q_mulx ^ (sq_r[cnt[SQ_IDX_W-1:0]] ? sq_r : '0);
      end
      OP_POW_BIT: begin
        if (n_r[WORD_W-1]) q_nxt = q_mulx;
        n_nxt = n_r << 1;
      end
      OP_ACC_CLEAR: acc_nxt = '0;
      OP_APPLY_STEP: begin
        if (q_r[0]) acc_nxt = acc_r ^ w_r;
        w_nxt = advance(w_r);
        q_nxt = q_r >> 1;
      end
      OP_WORD_LOAD: w_nxt = acc_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      charp_ok_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      charp_ok_r  <= charp_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r       <= w_nxt;
    acc_r     <= acc_nxt;
    exp_r     <= exp_nxt;
    mix_r     <= mix_nxt;
    prod_r    <= prod_nxt;
    n_r       <= n_nxt;
    q_r       <= q_nxt;
    sq_r      <= sq_nxt;
    charp_r   <= charp_nxt;
    c_r       <= c_nxt;
    bs_r      <= bs_nxt;
    hist_r    <= hist_nxt;
    l_r       <= l_nxt;
    out_val_r <= out_val_nxt;
  end

endmodule

// File: rtl/xoshiro_seq.sv
// Micro-program sequencer: step counter, control-word ROM, loop counters, jumps.
// Depends on xoshiro_pkg.
module xoshiro_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  xoshiro_pkg::seq_stat_t      stat,
  output xoshiro_pkg::ctl_t           ctl,
  output logic [xoshiro_pkg::CNT_W-1:0] cnt
);
  import xoshiro_pkg::*;

  upc_t              pc_r, pc_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [BITC_W-1:0] bit_cnt_r, bit_cnt_nxt;

  function automatic ctl_t cw(input dp_op_t op, input cnt_ld_t ld, input logic bit_ld,
                              input logic mul_b, input jmp_t jmp, input upc_t tgt);
    ctl_t r;
    r.op     = op;
    r.ld     = ld;
    r.bit_ld = bit_ld;
    r.mul_b  = mul_b;
    r.jmp    = jmp;
    r.target = tgt;
    cw = r;
  endfunction

  function automatic ctl_t ucode_rom(input upc_t pc);
    ctl_t r;
    unique case (pc)
      UPC_IDLE:     r = cw(OP_IDLE,       LD_3,    1'b0, 1'b0, JMP_DISPATCH, UPC_IDLE);
      UPC_BOOT:     r = cw(OP_BOOT,       LD_3,    1'b0, 1'b0, JMP_NEXT,     UPC_IDLE);
      UPC_SEED_MIX: r = cw(OP_EXP_MIX,    LD_NONE, 1'b0, 1'b0, JMP_NEXT,     UPC_IDLE);
      UPC_SEED_LLA: r = cw(OP_MUL_LL,     LD_NONE, 1'b0, 1'b0, JMP_NEXT,     UPC_IDLE);
      UPC_SEED_HLA: r = cw(OP_MUL_HL,     LD_NONE, 1'b0, 1'b0, JMP_NEXT,     UPC_IDLE);
      UPC_SEED_LHA: r = cw(OP_MUL_LH,     LD_NONE, 1'b0, 1'b0, JMP_NEXT,     UPC_IDLE);
      UPC_SEED_M27: r = cw(OP_MIX27,      LD_NONE, 1'b0, 1'b0, JMP_NEXT,     UPC_IDLE);
      UPC_SEED_LLB: r = cw(OP_MUL_LL,     LD_NONE, 1'b0, 1'b1, JMP_NEXT,     UPC_IDLE);
      UPC_SEED_HLB: r = cw(OP_MUL_HL,     LD_NONE, 1'b0, 1'b1, JMP_NEXT,     UPC_IDLE);
      UPC_SEED_LHB: r = cw(OP_MUL_LH,     LD_NONE, 1'b0, 1'b1, JMP_NEXT,     UPC_IDLE);
      UPC_SEED_WR:  r = cw(OP_WORD_SHIFT, LD_NONE, 1'b0, 1'b0, JMP_LOOP,     UPC_SEED_MIX);
      UPC_SEED_END: r = cw(OP_NOP,        LD_NONE, 1'b0, 1'b0, JMP_ALWAYS,   UPC_IDLE);
      UPC_DIS_ZERO: r = cw(OP_NOP,        LD_NONE, 1'b0, 1'b0, JMP_IF_NZERO, UPC_IDLE);
      UPC_DIS_CHK:  r = cw(OP_NOP,        LD_NONE, 1'b0, 1'b0, JMP_IF_CHARP, UPC_POW_INIT);
      UPC_BM_INIT:  r = cw(OP_BM_INIT,    LD_511,  1'b0, 1'b0, JMP_NEXT,     UPC_IDLE);
      UPC_BM_STEP:  r = cw(OP_BM_STEP,    LD_NONE, 1'b0, 1'b0, JMP_LOOP,     UPC_BM_STEP);
      UPC_BM_FIN:   r = cw(OP_BM_FIN,     LD_NONE, 1'b0, 1'b0, JMP_NEXT,     UPC_IDLE);
      UPC_POW_INIT: r = cw(OP_POW_INIT,   LD_NONE, 1'b1, 1'b0, JMP_NEXT,     UPC_IDLE);
      UPC_SQ_START: r = cw(OP_SQ_START,   LD_255,  1'b0, 1'b0, JMP_NEXT,     UPC_IDLE);
      UPC_SQ_STEP:  r = cw(OP_SQ_STEP,    LD_NONE, 1'b0, 1'b0, JMP_LOOP,     UPC_SQ_STEP);
      UPC_POW_BIT:  r = cw(OP_POW_BIT,    LD_NONE, 1'b0, 1'b0, JMP_LOOP_BIT, UPC_SQ_START);
      UPC_ACC_CLR:  r = cw(OP_ACC_CLEAR,  LD_255,  1'b0, 1'b0, JMP_NEXT,     UPC_IDLE);
      UPC_APPLY:    r = cw(OP_APPLY_STEP, LD_NONE, 1'b0, 1'b0, JMP_LOOP,     UPC_APPLY);
      UPC_LOAD:     r = cw(OP_WORD_LOAD,  LD_NONE, 1'b0, 1'b0, JMP_ALWAYS,   UPC_IDLE);
      default:      r = cw(OP_NOP,        LD_NONE, 1'b0, 1'b0, JMP_ALWAYS,   UPC_IDLE);
    endcase
    ucode_rom = r;
  endfunction

  function automatic upc_t dispatch_target(input logic [OPC_W-1:0] opc);
    upc_t t;
    case (opc)
      OPC_SEED:                 t = UPC_SEED_MIX;
      OPC_DISCARD:              t = UPC_DIS_ZERO;
      OPC_JUMP, OPC_LONG_JUMP:  t = UPC_ACC_CLR;
      default:                  t = UPC_IDLE;     // next is done in the idle step
    endcase
    dispatch_target = t;
  endfunction

  assign ctl = ucode_rom(pc_r);
  assign cnt = cnt_r;

  always_comb begin
    pc_nxt      = pc_r + 1'b1;
    cnt_nxt     = cnt_r;
    bit_cnt_nxt = bit_cnt_r;
    unique case (ctl.jmp)
      JMP_NEXT:     pc_nxt = pc_r + 1'b1;
      JMP_ALWAYS:   pc_nxt = ctl.target;
      JMP_LOOP: begin
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - 1'b1;
          pc_nxt  = ctl.target;
        end
      end
      JMP_LOOP_BIT: begin
        if (bit_cnt_r != '0) begin
          bit_cnt_nxt = bit_cnt_r - 1'b1;
          pc_nxt      = ctl.target;
        end
      end
      JMP_IF_NZERO: if (stat.n_zero) pc_nxt = ctl.target;
      JMP_IF_CHARP: if (stat.charp_ok) pc_nxt = ctl.target;
      JMP_DISPATCH: pc_nxt = stat.in_fire ? dispatch_target(stat.opcode) : pc_r;
      default:      pc_nxt = UPC_IDLE;
    endcase
    case (ctl.ld)
      LD_3:    cnt_nxt = CNT_W'(3);
      LD_255:  cnt_nxt = CNT_W'(POLY_W - 1);
      LD_511:  cnt_nxt = CNT_W'(2 * POLY_W - 1);
      default: ;
    endcase
    if (ctl.bit_ld) bit_cnt_nxt = BITC_W'(WORD_W - 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r      <= UPC_BOOT;
      cnt_r     <= '0;
      bit_cnt_r <= '0;
    end else begin
      pc_r      <= pc_nxt;
      cnt_r     <= cnt_nxt;
      bit_cnt_r <= bit_cnt_nxt;
    end
  end

endmodule
